FILE: hdl/activation_function_unit_macros.svh
// Assertion macros shared by the activation unit RTL.
// No dependencies; every user must provide clk and arst_n in scope.
`ifndef ACTIVATION_FUNCTION_UNIT_MACROS_SVH
`define ACTIVATION_FUNCTION_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define AFU_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset
`define AFU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/afu_pkg.sv
// Shared types and constants for the activation function unit.
// No dependencies.
package afu_pkg;

	// Default parameter values
	localparam int DATA_WIDTH_DEF  = 16;
	localparam int FRAC_BITS_DEF   = 10;
	localparam int TABLE_DEPTH_DEF = 256;

	// Fixed formats
	localparam int LEAK_WIDTH = 16;     // leak coefficient, Q1.14
	localparam int LEAK_FRAC  = 14;
	localparam int RANGE_LOG2 = 4;      // table covers 0..16
	localparam int Q30_FRAC   = 30;     // table entries are Q2.30
	localparam int ENTRY_W    = 31;     // holds 0..2^30
	localparam logic [ENTRY_W-1:0] ONE_Q30 = 31'h4000_0000;

	// Configuration port
	localparam int MODE_W    = 3;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LEAK = 2'd2;

	// Activation function codes (mode register values)
	typedef enum logic [MODE_W-1:0] {
		OP_NOOP    = 3'd0,
		OP_RELU    = 3'd1,
		OP_CLIP    = 3'd2,
		OP_LEAKY   = 3'd3,
		OP_TANH    = 3'd4,
		OP_SIGMOID = 3'd5
	} afu_op_t;

	// Side band that travels down the pipeline with each request
	typedef struct packed {
		logic    vld;
		logic    last;
		logic    neg;
		afu_op_t op;
	} afu_ctl_t;

endpackage

FILE: hdl/activation_function_unit.sv
// Activation function unit: element-wise relu, clipped relu, leaky relu,
// tanh and sigmoid on signed fixed-point samples.
// Depends on afu_pkg and afu_dp (which holds afu_sig_rom).
//
// Usage:
//   Input channel: sample/is_last with sample_valid/sample_ready.
//   Result channel: result/is_last_res with result_valid/result_ready.
//   Configuration: cfg_wr_en writes cfg_wdata into register cfg_index
//   (0 mode, 1 clip_limit, 2 leak_coefficient); other indexes are ignored.
//   Write configuration only while no request is in flight.
// Timing:
//   Five register stages. result_valid rises once an accepted request has
//   passed all five; one request per cycle is taken while the output moves.
//   The rate holds because the table read and every multiplier are pipelined.
//   In no-op mode (and modes 6, 7) requests are taken and give no result.
// Reset and stall:
//   arst_n clears all valid bits and configuration registers; the table is a
//   constant ROM and needs no fill. When result_ready is low with a result
//   waiting, the whole pipeline holds and sample_ready drops.
module activation_function_unit #(
	parameter int DATA_WIDTH  = afu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS   = afu_pkg::FRAC_BITS_DEF,
	parameter int TABLE_DEPTH = afu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   sample_valid,
	output logic                                   sample_ready,
	input  logic signed [DATA_WIDTH-1:0]           sample,
	input  logic                                   is_last,
	output logic                                   result_valid,
	input  logic                                   result_ready,
	output logic signed [DATA_WIDTH-1:0]           result,
	output logic                                   is_last_res,
	input  logic                                   cfg_wr_en,
	input  logic [afu_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  logic [((DATA_WIDTH > afu_pkg::LEAK_WIDTH) ?
		DATA_WIDTH : afu_pkg::LEAK_WIDTH)-1:0]     cfg_wdata
);

	logic [afu_pkg::MODE_W-1:0]            mode_q;
	logic signed [DATA_WIDTH-1:0]          clip_q;
	logic signed [afu_pkg::LEAK_WIDTH-1:0] leak_q;

	afu_pkg::afu_op_t  op_dec;
	afu_pkg::afu_ctl_t ctl_in;
	afu_pkg::afu_ctl_t ctl_out;
	logic              adv;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0;
			clip_q <= '0;
			leak_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				afu_pkg::REG_MODE: mode_q <= cfg_wdata[afu_pkg::MODE_W-1:0];
				afu_pkg::REG_CLIP: clip_q <= cfg_wdata[DATA_WIDTH-1:0];
				afu_pkg::REG_LEAK: leak_q <= cfg_wdata[afu_pkg::LEAK_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	// Mode decode; undefined modes act as no-op
	always_comb begin
		unique case (mode_q)
			afu_pkg::OP_RELU:    op_dec = afu_pkg::OP_RELU;
			afu_pkg::OP_CLIP:    op_dec = afu_pkg::OP_CLIP;
			afu_pkg::OP_LEAKY:   op_dec = afu_pkg::OP_LEAKY;
			afu_pkg::OP_TANH:    op_dec = afu_pkg::OP_TANH;
			afu_pkg::OP_SIGMOID: op_dec = afu_pkg::OP_SIGMOID;
			default:             op_dec = afu_pkg::OP_NOOP;
		endcase
	end

	// Pipeline moves unless a result is waiting on a stalled receiver
	assign adv          = !ctl_out.vld || result_ready;
	assign sample_ready = adv;

	always_comb begin
		ctl_in.vld  = sample_valid && (op_dec != afu_pkg::OP_NOOP);
		ctl_in.last = is_last;
		ctl_in.neg  = sample[DATA_WIDTH-1];
		ctl_in.op   = op_dec;
	end

	afu_dp #(
		.DATA_WIDTH (DATA_WIDTH),
		.FRAC_BITS  (FRAC_BITS),
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (adv),
		.ctl_in          (ctl_in),
		.sample          (sample),
		.clip_limit      (clip_q),
		.leak_coefficient(leak_q),
		.ctl_out         (ctl_out),
		.result          (result)
	);

	assign result_valid = ctl_out.vld;
	assign is_last_res  = ctl_out.last;

endmodule

FILE: hdl/afu_sig_rom.sv
// Sigmoid table ROM, TABLE_DEPTH+1 entries of Q2.30, two registered reads.
// Depends on afu_pkg. Contents are computed at elaboration.
module afu_sig_rom #(
	parameter int TABLE_DEPTH = afu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                   clk,
	input  logic                                   en,
	input  logic [$clog2(TABLE_DEPTH+1)-1:0]       addr,
	output logic [afu_pkg::ENTRY_W-1:0]            lo_s2,
	output logic [afu_pkg::ENTRY_W-1:0]            hi_s2
);

	localparam int ADDR_W = $clog2(TABLE_DEPTH + 1);
	localparam int E_W    = afu_pkg::ENTRY_W;
	// Table step in Q32
	localparam logic [63:0] STEP_H = (64'd1 << 36) / TABLE_DEPTH;

	typedef logic [E_W-1:0] rom_t [TABLE_DEPTH+1];

	// Shift-subtract divide, elaboration only
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] quo;
		logic [63:0] rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// entry k = 1 / (1 + e^(-16k/TABLE_DEPTH)) in Q2.30
	function automatic rom_t build_rom();
		rom_t        tbl;
		logic [63:0] term;
		logic [63:0] pos;
		logic [63:0] neg;
		logic [63:0] r;
		logic [63:0] t;
		logic [63:0] d;
		term = 64'd1 << 32;
		pos  = term;
		neg  = '0;
		// e^-h by Taylor series
		for (int n = 1; n <= 24; n++) begin
			term = long_div((term * STEP_H) >> 32, 64'(n));
			if (n[0]) begin
				neg = neg + term;
			end else begin
				pos = pos + term;
			end
		end
		r = pos - neg;
		t = 64'd1 << 32;
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			if (k > 0) begin
				t = (t * r + (64'd1 << 31)) >> 32;
			end
			d      = (64'd1 << 32) + t;
			tbl[k] = E_W'(long_div((64'd1 << 62) + (d >> 1), d));
		end
		return tbl;
	endfunction

	localparam rom_t SIG_ROM = build_rom();

	logic [ADDR_W-1:0] addr_nx;

	// Upper neighbor for interpolation; addr never exceeds TABLE_DEPTH-1
	assign addr_nx = addr + 1'b1;

	// Registered read of both neighbors
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s2 <= SIG_ROM[addr];
			hi_s2 <= SIG_ROM[addr_nx];
		end
	end

endmodule

FILE: hdl/afu_dp.sv
// Five-stage activation datapath: decode, table read, interpolate, combine, round.
// Depends on afu_pkg, afu_sig_rom and activation_function_unit_macros.svh.
`include "activation_function_unit_macros.svh"

module afu_dp #(
	parameter int DATA_WIDTH  = afu_pkg::DATA_WIDTH_DEF,
	parameter int FRAC_BITS   = afu_pkg::FRAC_BITS_DEF,
	parameter int TABLE_DEPTH = afu_pkg::TABLE_DEPTH_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  afu_pkg::afu_ctl_t                     ctl_in,
	input  logic signed [DATA_WIDTH-1:0]          sample,
	input  logic signed [DATA_WIDTH-1:0]          clip_limit,
	input  logic signed [afu_pkg::LEAK_WIDTH-1:0] leak_coefficient,
	output afu_pkg::afu_ctl_t                     ctl_out,
	output logic signed [DATA_WIDTH-1:0]          result
);

	localparam int DW       = DATA_WIDTH;
	localparam int LUT_FB   = FRAC_BITS + afu_pkg::RANGE_LOG2;
	localparam int MAG_W    = DW + 1;
	localparam int ADDR_W   = $clog2(TABLE_DEPTH + 1);
	localparam int S_RAW    = MAG_W + ADDR_W;
	localparam int S_W      = (S_RAW > LUT_FB) ? S_RAW : LUT_FB + 1;
	localparam int IDX_W    = S_W - LUT_FB;
	localparam int E_W      = afu_pkg::ENTRY_W;
	localparam int M_W      = E_W + LUT_FB;
	localparam int P_W      = DW + afu_pkg::LEAK_WIDTH;
	localparam int L_W      = P_W + 1;
	localparam int T_W      = E_W + 1;
	localparam int R_W      = T_W + 1;
	localparam int F_W      = 34;
	localparam int ROUND_SH = afu_pkg::Q30_FRAC - FRAC_BITS;

	localparam logic signed [L_W-1:0] LEAK_RND =
		{{(L_W - afu_pkg::LEAK_FRAC){1'b0}}, 1'b1, {(afu_pkg::LEAK_FRAC - 1){1'b0}}};
	localparam logic signed [L_W-1:0] L_MAX = {{(L_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic signed [L_W-1:0] L_MIN = {{(L_W - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
	localparam logic signed [F_W-1:0] F_MAX = {{(F_W - DW + 1){1'b0}}, {(DW - 1){1'b1}}};
	localparam logic signed [F_W-1:0] F_MIN = {{(F_W - DW + 1){1'b1}}, {(DW - 1){1'b0}}};
	localparam logic [R_W-1:0] R_HALF = R_W'(64'd1 << (ROUND_SH - 1));

	// Stage 0 (input decode)
	logic [MAG_W-1:0]  x_ext;
	logic [MAG_W-1:0]  mag;
	logic [MAG_W-1:0]  lut_arg;
	logic [S_W-1:0]    scaled;
	logic [IDX_W-1:0]  idx_raw;
	logic              sat_in;
	logic [ADDR_W-1:0] addr_in;

	// Pipeline registers
	afu_pkg::afu_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4, ctl_s5;
	logic signed [DW-1:0]  x_s1, x_s2;
	logic [ADDR_W-1:0]     addr_s1;
	logic [LUT_FB-1:0]     frac_s1, frac_s2;
	logic                  sat_s1, sat_s2, sat_s3;
	logic [E_W-1:0]        lo_s2, hi_s2, lo_s3, ipol_s3, v_s4;
	logic signed [P_W-1:0] prod_s2;
	logic                  up_s3;
	logic signed [DW-1:0]  lin_s3, lin_s4, result_s5;

	// Stage 2 -> 3 logic
	logic                  up;
	logic [E_W-1:0]        dmag;
	logic [M_W-1:0]        ipol_full;
	logic                  x_pos;
	logic signed [DW-1:0]  clip_min;
	logic signed [DW-1:0]  clip_y;
	logic signed [L_W-1:0] lsum;
	logic signed [L_W-1:0] lsh;
	logic signed [DW-1:0]  leak_y;
	logic signed [DW-1:0]  lin;

	// Stage 3 -> 4 and 4 -> 5 logic
	logic [E_W-1:0]        v;
	logic [T_W-1:0]        tanh_val;
	logic [T_W-1:0]        sig_val;
	logic [T_W-1:0]        pre;
	logic [R_W-1:0]        rnd;
	logic signed [F_W-1:0] lut_res;
	logic signed [DW-1:0]  lut_y;
	logic signed [DW-1:0]  res_nx;

	// Magnitude, table index and fraction
	assign x_ext   = {sample[DW-1], sample};
	assign mag     = sample[DW-1] ? (~x_ext + 1'b1) : x_ext;
	assign lut_arg = (ctl_in.op == afu_pkg::OP_TANH) ? {mag[MAG_W-2:0], 1'b0} : mag;
	assign scaled  = S_W'(lut_arg) * S_W'(TABLE_DEPTH);
	assign idx_raw = scaled[S_W-1:LUT_FB];
	assign sat_in  = (64'(idx_raw) >= 64'(TABLE_DEPTH));
	assign addr_in = sat_in ? '0 : ADDR_W'(idx_raw);

	// Control side band, reset clears valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
			ctl_s5 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
			ctl_s5 <= ctl_s4;
		end
	end

	// Stage 1 and 2 payload; table data comes from the ROM
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1    <= sample;
			addr_s1 <= addr_in;
			frac_s1 <= scaled[LUT_FB-1:0];
			sat_s1  <= sat_in;
			x_s2    <= x_s1;
			frac_s2 <= frac_s1;
			sat_s2  <= sat_s1;
			prod_s2 <= P_W'(x_s1) * P_W'(leak_coefficient);
		end
	end

	afu_sig_rom #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_rom (
		.clk  (clk),
		.en   (en),
		.addr (addr_s1),
		.lo_s2(lo_s2),
		.hi_s2(hi_s2)
	);

	// Interpolation step: |hi-lo| * frac, truncated toward zero
	assign up        = (hi_s2 >= lo_s2);
	assign dmag      = up ? (hi_s2 - lo_s2) : (lo_s2 - hi_s2);
	assign ipol_full = M_W'(dmag) * M_W'(frac_s2);

	// Linear functions
	assign x_pos    = !x_s2[DW-1] && (x_s2 != '0);
	assign clip_min = (x_s2 < clip_limit) ? x_s2 : clip_limit;
	assign clip_y   = clip_min[DW-1] ? '0 : clip_min;
	assign lsum     = L_W'(prod_s2) + LEAK_RND;
	assign lsh      = lsum >>> afu_pkg::LEAK_FRAC;

	always_comb begin
		if (lsh > L_MAX) begin
			leak_y = L_MAX[DW-1:0];
		end else if (lsh < L_MIN) begin
			leak_y = L_MIN[DW-1:0];
		end else begin
			leak_y = lsh[DW-1:0];
		end
	end

	always_comb begin
		unique case (ctl_s2.op)
			afu_pkg::OP_RELU:  lin = x_pos ? x_s2 : '0;
			afu_pkg::OP_CLIP:  lin = clip_y;
			afu_pkg::OP_LEAKY: lin = x_pos ? x_s2 : leak_y;
			default:           lin = x_s2;
		endcase
	end

	// Stage 3 and 4 payload
	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3   <= lo_s2;
			ipol_s3 <= ipol_full[M_W-1:LUT_FB];
			up_s3   <= up;
			sat_s3  <= sat_s2;
			lin_s3  <= lin;
			v_s4    <= v;
			lin_s4  <= lin_s3;
		end
	end

	// Interpolated sigmoid value in Q2.30
	assign v = sat_s3 ? afu_pkg::ONE_Q30 : (up_s3 ? lo_s3 + ipol_s3 : lo_s3 - ipol_s3);

	// tanh = 2*sigmoid(2|x|) - 1; sigmoid(-x) = 1 - sigmoid(x)
	assign tanh_val = {v_s4, 1'b0} - T_W'(afu_pkg::ONE_Q30);
	assign sig_val  = ctl_s4.neg ? T_W'(afu_pkg::ONE_Q30 - v_s4) : T_W'(v_s4);
	assign pre      = (ctl_s4.op == afu_pkg::OP_TANH) ? tanh_val : sig_val;
	assign rnd      = (R_W'(pre) + R_HALF) >> ROUND_SH;

	always_comb begin
		if (ctl_s4.op == afu_pkg::OP_TANH && ctl_s4.neg) begin
			lut_res = -$signed(F_W'(rnd));
		end else begin
			lut_res = $signed(F_W'(rnd));
		end
		if (lut_res > F_MAX) begin
			lut_y = F_MAX[DW-1:0];
		end else if (lut_res < F_MIN) begin
			lut_y = F_MIN[DW-1:0];
		end else begin
			lut_y = lut_res[DW-1:0];
		end
	end

	assign res_nx = (ctl_s4.op == afu_pkg::OP_TANH || ctl_s4.op == afu_pkg::OP_SIGMOID)
		? lut_y : lin_s4;

	// Output register
	always_ff @(posedge clk) begin
		if (en) begin
			result_s5 <= res_nx;
		end
	end

	assign ctl_out = ctl_s5;
	assign result  = result_s5;

	`AFU_ASSERT_NEXT(a_vld_advances, en && ctl_s1.vld, ctl_s2.vld,
		"valid bit lost between stage 1 and 2")
	`AFU_ASSERT_SAME(a_sig_range, ctl_s4.vld &&
		(ctl_s4.op == afu_pkg::OP_TANH || ctl_s4.op == afu_pkg::OP_SIGMOID),
		v_s4 >= (afu_pkg::ONE_Q30 >> 1) && v_s4 <= afu_pkg::ONE_Q30,
		"interpolated sigmoid outside [0.5, 1.0]")
	`AFU_ASSERT_SAME(a_sigmoid_nonneg, ctl_s5.vld && ctl_s5.op == afu_pkg::OP_SIGMOID,
		!result_s5[DW-1], "negative sigmoid result")
	`AFU_ASSERT_SAME(a_relu_nonneg, ctl_s5.vld &&
		(ctl_s5.op == afu_pkg::OP_RELU || ctl_s5.op == afu_pkg::OP_CLIP),
		!result_s5[DW-1], "negative relu result")

endmodule

FILE: sim/activation_function_unit_checker.sv
// Scoreboard for the activation function unit: watches the config port and both
// request channels, predicts each result and compares it with what comes out.
// Depends on afu_pkg.
module activation_function_unit_checker
	import afu_pkg::*;
(
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	input  logic                              sample_ready,
	input  logic signed [DATA_WIDTH_DEF-1:0]  sample,
	input  logic                              is_last,
	input  logic                              result_valid,
	input  logic                              result_ready,
	input  logic signed [DATA_WIDTH_DEF-1:0]  result,
	input  logic                              is_last_res,
	input  logic                              cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]              cfg_index,
	input  logic [((DATA_WIDTH_DEF > LEAK_WIDTH) ?
		DATA_WIDTH_DEF : LEAK_WIDTH)-1:0]     cfg_wdata,
	output int                                mismatch_count,
	output int                                results_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int DW          = DATA_WIDTH_DEF;
	localparam int TD          = TABLE_DEPTH_DEF;
	localparam int FRAC_ALL    = FRAC_BITS_DEF + RANGE_LOG2;  // index/fraction split
	localparam int ROUND_SHIFT = Q30_FRAC - FRAC_BITS_DEF;
	localparam int REPORT_MAX  = 10;
	localparam longint signed OUT_MAX   = (64'sd1 <<< (DW - 1)) - 1;
	localparam longint signed OUT_MIN   = -OUT_MAX - 1;
	localparam longint signed LEAK_HALF = 64'sd1 <<< (LEAK_FRAC - 1);

	typedef struct packed {
		logic signed [DW-1:0] value;
		logic                 last;
	} activation_t;

	longint unsigned   sigmoid_q30 [0:TD];
	logic [MODE_W-1:0] mode_reg;
	longint signed     clip_reg;
	longint signed     leak_reg;
	activation_t       pending_q [$];

	// Sigmoid samples on 0..16 in Q2.30, built with integer math only
	initial begin : build_sigmoid
		longint unsigned step, term, pos_sum, neg_sum, decay, tk, den;
		step    = (64'd1 << 36) / TD;
		term    = 64'd1 << 32;
		pos_sum = term;
		neg_sum = 0;
		// e^-step by Taylor series in Q32
		for (int n = 1; n <= 24; n++) begin
			term = ((term * step) >> 32) / n;
			if (n % 2)
				neg_sum += term;
			else
				pos_sum += term;
		end
		decay = pos_sum - neg_sum;
		tk    = 64'd1 << 32;
		for (int k = 0; k <= TD; k++) begin
			if (k > 0)
				tk = (tk * decay + (64'd1 << 31)) >> 32;
			den            = (64'd1 << 32) + tk;
			sigmoid_q30[k] = ((64'd1 << 62) + (den >> 1)) / den;
		end
	end

	// Interpolated sigmoid of a Q10 magnitude, Q30 result
	function automatic longint unsigned sigmoid_interp(input longint unsigned mag);
		longint unsigned scaled, idx, frac, lo, hi;
		scaled = mag * TD;
		idx    = scaled >> FRAC_ALL;
		frac   = scaled & ((64'd1 << FRAC_ALL) - 1);
		if (idx >= TD)
			return ONE_Q30;
		lo = sigmoid_q30[idx];
		hi = sigmoid_q30[idx + 1];
		if (hi >= lo)
			return lo + (((hi - lo) * frac) >> FRAC_ALL);
		return lo - (((lo - hi) * frac) >> FRAC_ALL);
	endfunction

	// Q30 to Q10, round half up
	function automatic longint signed round_to_q10(input longint unsigned v);
		return longint'((v + (64'd1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
	endfunction

	// Returns 0 when the current mode gives no result
	function automatic bit activate(input logic signed [DW-1:0] x,
		output logic signed [DW-1:0] y);
		longint signed   xs, ys;
		longint unsigned mag, v, one;
		xs  = x;
		one = ONE_Q30;
		mag = (xs < 0) ? -xs : xs;
		case (mode_reg)
			OP_RELU: ys = (xs > 0) ? xs : 0;
			OP_CLIP: begin
				ys = (xs < clip_reg) ? xs : clip_reg;
				if (ys < 0)
					ys = 0;
			end
			OP_LEAKY: ys = (xs > 0) ? xs : ((xs * leak_reg + LEAK_HALF) >>> LEAK_FRAC);
			OP_TANH: begin
				// tanh(x) = 2*sigmoid(2x) - 1, sign restored afterwards
				v  = sigmoid_interp(mag << 1);
				ys = round_to_q10(2 * v - one);
				if (xs < 0)
					ys = -ys;
			end
			OP_SIGMOID: begin
				v  = sigmoid_interp(mag);
				ys = round_to_q10((xs < 0) ? one - v : v);
			end
			default: return 1'b0;
		endcase
		if (ys > OUT_MAX)
			ys = OUT_MAX;
		else if (ys < OUT_MIN)
			ys = OUT_MIN;
		y = ys[DW-1:0];
		return 1'b1;
	endfunction

	task automatic report(input string msg);
		mismatch_count++;
		if (mismatch_count <= REPORT_MAX)
			$display("%0t ns: %s", $time, msg);
	endtask

	// Compare on the result channel, predict on the input channel, track config
	always @(posedge clk or negedge arst_n) begin : score
		activation_t          want;
		logic signed [DW-1:0] predicted;
		if (!arst_n) begin
			mode_reg = OP_NOOP;
			clip_reg = 0;
			leak_reg = 0;
			pending_q.delete();
			results_pending <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (pending_q.size() == 0) begin
					report($sformatf("result %0d (last %0b) with no request outstanding",
						result, is_last_res));
				end else begin
					want = pending_q.pop_front();
					if (result !== want.value)
						report($sformatf("result: expected %0d, got %0d", want.value, result));
					if (is_last_res !== want.last)
						report($sformatf("is_last_res: expected %0b, got %0b",
							want.last, is_last_res));
				end
			end
			if (sample_valid && sample_ready && activate(sample, predicted))
				pending_q.push_back('{value: predicted, last: is_last});
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_MODE: mode_reg = cfg_wdata[MODE_W-1:0];
					REG_CLIP: clip_reg = $signed(cfg_wdata[DW-1:0]);
					REG_LEAK: leak_reg = $signed(cfg_wdata[LEAK_WIDTH-1:0]);
					default: ;
				endcase
			end
			results_pending <= pending_q.size();
		end
	end

endmodule

FILE: sim/activation_function_unit_test.sv
// Top of the activation function unit testbench: clock, reset, config phases,
// sample stimulus, result back-pressure, watchdog and verdict.
// Depends on afu_pkg, activation_function_unit and activation_function_unit_checker.
module activation_function_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import afu_pkg::*;

	localparam int DW    = DATA_WIDTH_DEF;
	localparam int CFG_W = (DW > LEAK_WIDTH) ? DW : LEAK_WIDTH;
	localparam logic [MODE_W-1:0]    MODE_RSVD6 = 3'd6;
	localparam logic [MODE_W-1:0]    MODE_RSVD7 = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE  = 2'd3;
	localparam int PIPE_SETTLE    = 8;     // five stages plus margin
	localparam int IDLE_PCT       = 30;
	localparam int MAX_GAP        = 12;
	localparam int HOLD_CYCLES    = 64;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int RANDOM_ITEMS   = 1400;

	logic                 clk          = 1'b0;
	logic                 arst_n       = 1'b0;
	logic                 sample_valid = 1'b0;
	logic signed [DW-1:0] sample       = '0;
	logic                 is_last      = 1'b0;
	logic                 result_ready = 1'b0;
	logic                 cfg_wr_en    = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index    = '0;
	logic [CFG_W-1:0]     cfg_wdata    = '0;
	logic                 sample_ready;
	logic                 result_valid;
	logic signed [DW-1:0] result;
	logic                 is_last_res;
	int                   mismatch_count;
	int                   results_pending;

	bit sender_idles   = 1'b1;
	bit receiver_idles = 1'b1;
	bit hold_request   = 1'b0;
	int hold_left      = 0;
	int quiet_cycles   = 0;

	activation_function_unit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.sample       (sample),
		.is_last      (is_last),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.is_last_res  (is_last_res),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	activation_function_unit_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_valid    (sample_valid),
		.sample_ready    (sample_ready),
		.sample          (sample),
		.is_last         (is_last),
		.result_valid    (result_valid),
		.result_ready    (result_ready),
		.result          (result),
		.is_last_res     (is_last_res),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_index       (cfg_index),
		.cfg_wdata       (cfg_wdata),
		.mismatch_count  (mismatch_count),
		.results_pending (results_pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Result side: random stalls, plus a long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			result_ready <= 1'b0;
			hold_left--;
		end else if (hold_request) begin
			hold_request = 1'b0;
			hold_left    = HOLD_CYCLES - 1;
			result_ready <= 1'b0;
		end else begin
			result_ready <= !receiver_idles || ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// Watchdog: end the run when no request moves for too long
	always @(posedge clk) begin
		if (!arst_n || (sample_valid && sample_ready) || (result_valid && result_ready)
			|| cfg_wr_en) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no request moved for %0d cycles", quiet_cycles);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Offer one sample, optionally after a random gap, and wait for acceptance
	task automatic offer_sample(input int value, input logic last);
		int gap;
		gap = 0;
		if (sender_idles)
			while (gap < MAX_GAP && $urandom_range(99) < IDLE_PCT)
				gap++;
		if (gap > 0) begin
			sample_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		sample_valid <= 1'b1;
		sample       <= DW'(value);
		is_last      <= last;
		do
			@(posedge clk);
		while (!sample_ready);
	endtask

	// Stop sending and wait for every predicted result to come back
	task automatic wait_drained();
		sample_valid <= 1'b0;
		do
			@(posedge clk);
		while (results_pending != 0);
	endtask

	// Write all registers once the pipeline is empty; the spare index is
	// written with junk and must be ignored
	task automatic reconfigure(input logic [MODE_W-1:0] mode_code,
		input int clip, input int leak);
		logic [CFG_W-1:0] word;
		wait_drained();
		repeat (PIPE_SETTLE) @(posedge clk);
		word               = CFG_W'($urandom);
		word[MODE_W-1:0]   = mode_code;
		cfg_wr_en <= 1'b1;
		cfg_index <= REG_MODE;
		cfg_wdata <= word;
		@(posedge clk);
		cfg_index <= REG_CLIP;
		cfg_wdata <= CFG_W'(clip);
		@(posedge clk);
		cfg_index <= REG_LEAK;
		cfg_wdata <= CFG_W'(leak);
		@(posedge clk);
		cfg_index <= REG_SPARE;
		cfg_wdata <= CFG_W'($urandom);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	initial begin : stimulus
		int                produced, phase_no, phase_len, pick;
		int                clip, leak, value;
		logic [MODE_W-1:0] mode_code;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: range extremes per function
		reconfigure(OP_RELU, 0, 0);
		offer_sample(32767, 1'b0);
		offer_sample(-32768, 1'b1);
		offer_sample(0, 1'b0);
		offer_sample(1, 1'b1);
		offer_sample(-1, 1'b0);
		// negative clip limit forces zero
		reconfigure(OP_CLIP, -1024, 0);
		offer_sample(5000, 1'b0);
		offer_sample(-5, 1'b1);
		reconfigure(OP_CLIP, 2048, 0);
		offer_sample(32767, 1'b0);
		offer_sample(2048, 1'b0);
		offer_sample(1000, 1'b1);
		// most negative slope times most negative sample overflows high
		reconfigure(OP_LEAKY, 0, -32768);
		offer_sample(-32768, 1'b0);
		offer_sample(32767, 1'b0);
		offer_sample(-1, 1'b1);
		reconfigure(OP_LEAKY, 0, 32767);
		offer_sample(-32768, 1'b1);
		// tanh and sigmoid at zero, at the table edge and past it
		reconfigure(OP_TANH, 0, 0);
		offer_sample(32767, 1'b0);
		offer_sample(-32768, 1'b0);
		offer_sample(0, 1'b0);
		offer_sample(8192, 1'b1);
		offer_sample(-1, 1'b0);
		reconfigure(OP_SIGMOID, 0, 0);
		offer_sample(16384, 1'b0);
		offer_sample(-16384, 1'b0);
		offer_sample(0, 1'b1);
		offer_sample(-32768, 1'b0);
		// no-op and undefined modes swallow requests
		reconfigure(OP_NOOP, 0, 0);
		offer_sample(100, 1'b1);
		reconfigure(MODE_RSVD6, 0, 0);
		offer_sample(5, 1'b0);
		reconfigure(MODE_RSVD7, 0, 0);
		offer_sample(-5, 1'b1);

		// Random phases, each with its own register setting
		produced = 0;
		phase_no = 0;
		while (produced < RANDOM_ITEMS) begin
			if ($urandom_range(99) < 8) begin
				case ($urandom_range(2))
					0: mode_code = OP_NOOP;
					1: mode_code = MODE_RSVD6;
					default: mode_code = MODE_RSVD7;
				endcase
			end else begin
				mode_code = MODE_W'(OP_RELU + $urandom_range(4));
			end
			case ($urandom_range(5))
				0: clip = -32768;
				1: clip = 32767;
				2: clip = 0;
				3: clip = $urandom_range(4096);
				4: clip = -$urandom_range(1, 4096);
				default: clip = $urandom;
			endcase
			case ($urandom_range(5))
				0: leak = -32768;
				1: leak = 32767;
				2: leak = 0;
				3: leak = 16384;
				4: leak = $urandom_range(4096);
				default: leak = $urandom;
			endcase
			// every tenth phase runs flat out on both sides
			sender_idles   = (phase_no % 10 != 3);
			receiver_idles = (phase_no % 10 != 3);
			reconfigure(mode_code, clip, leak);

			phase_len = $urandom_range(20, 80);
			for (int i = 0; i < phase_len; i++) begin
				if (i == 5 && phase_no % 7 == 2)
					hold_request = 1'b1;
				if (i == phase_len / 2 && phase_no % 9 == 5)
					wait_drained();
				pick = $urandom_range(99);
				if (pick < 10) begin
					case ($urandom_range(3))
						0: value = 32767;
						1: value = -32768;
						2: value = 0;
						default: value = -1;
					endcase
				end else if (pick < 55) begin
					// mostly within the table span
					value = $urandom_range(32768) - 16384;
				end else begin
					value = $urandom;
				end
				offer_sample(value, $urandom_range(7) == 0);
				if (mode_code >= OP_RELU && mode_code <= OP_SIGMOID)
					produced++;
			end
			phase_no++;
		end

		wait_drained();
		repeat (PIPE_SETTLE) @(posedge clk);
		if (mismatch_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

FILE: files.f
+incdir+hdl
hdl/afu_pkg.sv
hdl/afu_sig_rom.sv
hdl/afu_dp.sv
hdl/activation_function_unit.sv
sim/activation_function_unit_checker.sv
sim/activation_function_unit_test.sv
